>>> hdl/ddm_pkg.sv
package ddm_pkg;

  localparam int CH_W   = 11;
  localparam int SENS_W = 4;
  localparam int DUTY_W = 8;
  localparam int NUM_W  = CH_W + DUTY_W;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = ADDR_W - 2;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [DUTY_W-1:0] duty_t;
  typedef logic [NUM_W-1:0]  num_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SENSITIVITY,
    REG_CHANNEL_MIN,
    REG_CHANNEL_MAX,
    REG_CHANNEL_MID,
    REG_STEER_CENTER
  } reg_idx_t;

endpackage

>>> hdl/differential_drive_mixer_unit.sv
// Channel   | Signals                                        | Moves
// frame     | frame_valid, frame_ready, throttle/steer_chan  | one radio frame in
// duty      | duty_valid, duty_ready, duty_left, duty_right  | one pair of motor duties out
// apb       | psel, penable, pwrite, paddr, pwdata, prdata   | five control registers
//
// A new request is taken in the cycle after the result is registered.
// The gain multiply is bit-serial, and the two bit-serial divisions for the duty
// scaling share one divider.
// Synchronous reset restores register defaults and clears all wheel state.
// A stalled result is held in the output register; the next frame waits only while it
// cannot be handed over.
module differential_drive_mixer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        frame_valid,
  output logic                        frame_ready,
  input  ddm_pkg::chan_t              throttle_channel,
  input  ddm_pkg::chan_t              steer_channel,
  output logic                        duty_valid,
  input  logic                        duty_ready,
  output ddm_pkg::duty_t              duty_left,
  output ddm_pkg::duty_t              duty_right,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ddm_pkg::ADDR_W-1:0]  paddr,
  input  logic [ddm_pkg::DATA_W-1:0]  pwdata,
  output logic [ddm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int SUM_W  = 18;
  localparam int DIFF_W = ddm_pkg::CH_W + 2;

  localparam logic [ddm_pkg::SENS_W-1:0] SENS_RST = 4'd1;
  localparam ddm_pkg::chan_t MIN_RST    = 11'd172;
  localparam ddm_pkg::chan_t MAX_RST    = 11'd1811;
  localparam ddm_pkg::chan_t MID_RST    = 11'd992;
  localparam ddm_pkg::chan_t CENTER_RST = 11'd991;

  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MIX, S_STEER, S_MUL, S_APPLY, S_CLAMP,
    S_DIV_L, S_WAIT_L, S_DIV_R, S_WAIT_R, S_FINISH
  } state_t;

  typedef enum logic [1:0] {SIDE_NONE, SIDE_LEFT, SIDE_RIGHT} side_t;

  state_t state;
  side_t  side;

  logic [ddm_pkg::SENS_W-1:0] sensitivity;
  ddm_pkg::chan_t channel_min, channel_max, channel_mid, steer_center;

  ddm_pkg::chan_t wheel_speed_left, wheel_speed_right;
  ddm_pkg::chan_t prev_throttle, prev_left_steer, prev_right_steer;

  ddm_pkg::chan_t thr, steer, steer_clamped, mag;
  diff_t          delta;
  sum_t           speed_left, speed_right;
  sum_t           acc, mcand;
  logic [ddm_pkg::SENS_W-1:0] gain_bits;
  logic [1:0]     mul_cnt;
  ddm_pkg::duty_t quot_left;

  // Combinational terms.
  function automatic sum_t ext(input ddm_pkg::chan_t v);
    ext = $signed({{(SUM_W-ddm_pkg::CH_W){1'b0}}, v});
  endfunction

  function automatic ddm_pkg::chan_t abs_diff(input ddm_pkg::chan_t a, input ddm_pkg::chan_t b);
    abs_diff = (a >= b) ? a - b : b - a;
  endfunction

  function automatic ddm_pkg::num_t scale_num(input ddm_pkg::chan_t v, input ddm_pkg::chan_t lo);
    ddm_pkg::chan_t a;
    a = abs_diff(v, lo);
    scale_num = {a, {ddm_pkg::DUTY_W{1'b0}}} - {{ddm_pkg::DUTY_W{1'b0}}, a};
  endfunction

  sum_t           sl_mix, sr_mix, thr_e, abs_k, sl_apply, sr_apply;
  sum_t           lo_e, hi_e;
  ddm_pkg::chan_t st_clamp_c, mag_left, ws_l_clamp, ws_r_clamp;
  logic signed [ddm_pkg::CH_W:0] mag_right;
  diff_t          diff_left, diff_right;
  logic           span_zero;
  logic           div_start, div_done;
  ddm_pkg::num_t  div_num;
  ddm_pkg::chan_t div_den;
  ddm_pkg::duty_t div_quot;

  assign thr_e  = ext(thr);
  assign lo_e   = ext(channel_min);
  assign hi_e   = ext(channel_max);
  assign sl_mix = ext(wheel_speed_left) + thr_e - ext(prev_throttle);
  assign sr_mix = ext(wheel_speed_right) + thr_e - ext(prev_throttle);

  // The floor is tested first, which decides the result of an inverted range.
  assign st_clamp_c = (steer < channel_min) ? channel_min :
                      (steer > channel_max) ? channel_max : steer;

  assign mag_left   = abs_diff(steer_clamped, steer_center);
  assign mag_right  = $signed({1'b0, steer_clamped}) - $signed({1'b0, steer_center});
  assign diff_left  = $signed({2'b00, mag_left}) - $signed({2'b00, prev_left_steer});
  assign diff_right = $signed({mag_right[ddm_pkg::CH_W], mag_right})
                    - $signed({2'b00, prev_right_steer});

  assign abs_k = acc[SUM_W-1] ? -acc : acc;

  always_comb begin
    sl_apply = speed_left;
    sr_apply = speed_right;
    case (side)
      SIDE_LEFT: begin
        if (speed_left > thr_e) begin
          sl_apply = speed_left - abs_k;
        end else if (speed_left < thr_e) begin
          sl_apply = speed_left + abs_k;
        end
        sr_apply = speed_right + acc;
      end
      SIDE_RIGHT: begin
        sl_apply = speed_left + acc;
        if (speed_right < thr_e) begin
          sr_apply = speed_right + abs_k;
        end else if (speed_right > thr_e) begin
          sr_apply = speed_right - abs_k;
        end
      end
      default: begin
      end
    endcase
  end

  assign ws_l_clamp = (speed_left < lo_e) ? channel_min :
                      (speed_left > hi_e) ? channel_max : speed_left[ddm_pkg::CH_W-1:0];
  assign ws_r_clamp = (speed_right < lo_e) ? channel_min :
                      (speed_right > hi_e) ? channel_max : speed_right[ddm_pkg::CH_W-1:0];

  assign span_zero = (channel_min == channel_max);
  assign div_den   = abs_diff(channel_max, channel_min);
  assign div_start = (state == S_DIV_L) || (state == S_DIV_R);
  assign div_num   = (state == S_DIV_L) ? scale_num(wheel_speed_left, channel_min)
                                        : scale_num(wheel_speed_right, channel_min);

  ddm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign frame_ready = (state == S_IDLE);
  assign pready      = 1'b1;

  always_comb begin
    unique case (paddr[ddm_pkg::ADDR_W-1:2])
      ddm_pkg::REG_SENSITIVITY:  prdata = ddm_pkg::DATA_W'(sensitivity);
      ddm_pkg::REG_CHANNEL_MIN:  prdata = ddm_pkg::DATA_W'(channel_min);
      ddm_pkg::REG_CHANNEL_MAX:  prdata = ddm_pkg::DATA_W'(channel_max);
      ddm_pkg::REG_CHANNEL_MID:  prdata = ddm_pkg::DATA_W'(channel_mid);
      ddm_pkg::REG_STEER_CENTER: prdata = ddm_pkg::DATA_W'(steer_center);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity  <= SENS_RST;
      channel_min  <= MIN_RST;
      channel_max  <= MAX_RST;
      channel_mid  <= MID_RST;
      steer_center <= CENTER_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[ddm_pkg::ADDR_W-1:2])
        ddm_pkg::REG_SENSITIVITY:  sensitivity  <= pwdata[ddm_pkg::SENS_W-1:0];
        ddm_pkg::REG_CHANNEL_MIN:  channel_min  <= pwdata[ddm_pkg::CH_W-1:0];
        ddm_pkg::REG_CHANNEL_MAX:  channel_max  <= pwdata[ddm_pkg::CH_W-1:0];
        ddm_pkg::REG_CHANNEL_MID:  channel_mid  <= pwdata[ddm_pkg::CH_W-1:0];
        ddm_pkg::REG_STEER_CENTER: steer_center <= pwdata[ddm_pkg::CH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      duty_valid        <= 1'b0;
      wheel_speed_left  <= '0;
      wheel_speed_right <= '0;
      prev_throttle     <= '0;
      prev_left_steer   <= '0;
      prev_right_steer  <= '0;
    end else begin
      // In the finish step the handover of the old result is handled there.
      if (duty_valid && duty_ready && state != S_FINISH) begin
        duty_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (frame_valid) begin
            thr   <= throttle_channel;
            steer <= steer_channel;
            state <= S_MIX;
          end
        end
        S_MIX: begin
          speed_left    <= sl_mix;
          speed_right   <= sr_mix;
          steer_clamped <= st_clamp_c;
          prev_throttle <= thr;
          state         <= S_STEER;
        end
        S_STEER: begin
          // A side whose magnitude is unchanged gets a zero product and so does nothing.
          if (steer_clamped < channel_mid) begin
            side  <= SIDE_LEFT;
            delta <= diff_left;
            mag   <= mag_left;
            mcand <= SUM_W'(diff_left);
          end else if (steer_clamped > channel_mid) begin
            side  <= SIDE_RIGHT;
            delta <= diff_right;
            mag   <= mag_right[ddm_pkg::CH_W-1:0];
            mcand <= SUM_W'(diff_right);
          end else begin
            side  <= SIDE_NONE;
            delta <= '0;
            mag   <= '0;
            mcand <= '0;
          end
          acc       <= '0;
          gain_bits <= sensitivity;
          mul_cnt   <= '0;
          state     <= S_MUL;
        end
        S_MUL: begin
          if (gain_bits[0]) begin
            acc <= acc + mcand;
          end
          mcand     <= mcand <<< 1;
          gain_bits <= gain_bits >> 1;
          mul_cnt   <= mul_cnt + 1'b1;
          if (mul_cnt == 2'(ddm_pkg::SENS_W - 1)) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          speed_left  <= sl_apply;
          speed_right <= sr_apply;
          if (side == SIDE_LEFT && delta != '0) begin
            prev_left_steer <= mag;
          end
          if (side == SIDE_RIGHT && delta != '0) begin
            prev_right_steer <= mag;
          end
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          wheel_speed_left  <= ws_l_clamp;
          wheel_speed_right <= ws_r_clamp;
          state             <= S_DIV_L;
        end
        S_DIV_L: begin
          state <= S_WAIT_L;
        end
        S_WAIT_L: begin
          if (div_done) begin
            quot_left <= div_quot;
            state     <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          state <= S_WAIT_R;
        end
        S_WAIT_R: begin
          if (div_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!duty_valid || duty_ready) begin
            duty_left  <= span_zero ? '0 : quot_left;
            duty_right <= span_zero ? '0 : div_quot;
            duty_valid <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/ddm_div.sv
// Restoring divider that produces one quotient bit per cycle, most significant first.
// The quotient must be known to fit in DUTY_W bits.
module ddm_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ddm_pkg::num_t      num,
  input  ddm_pkg::chan_t     den,
  output logic               done,
  output ddm_pkg::duty_t     quot
);

  localparam int DSH_W = ddm_pkg::NUM_W - 1;
  localparam int CNT_W = $clog2(ddm_pkg::DUTY_W);

  logic [ddm_pkg::NUM_W-1:0] rem;
  logic [DSH_W-1:0]          dsh;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      ge;
  logic [ddm_pkg::NUM_W-1:0] rem_diff;

  assign ge       = ({1'b0, dsh} <= rem);
  assign rem_diff = rem - {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ddm_pkg::DUTY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= {den, {(ddm_pkg::DUTY_W-1){1'b0}}};
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem_diff;
      end
      quot <= {quot[ddm_pkg::DUTY_W-2:0], ge};
      dsh  <= dsh >> 1;
    end
  end

endmodule

>>> hdl/ddm_checker.sv
module ddm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        frame_valid,
  input logic                        frame_ready,
  input logic                        duty_valid,
  input logic                        duty_ready,
  input ddm_pkg::duty_t              duty_left,
  input ddm_pkg::duty_t              duty_right
);

  // A result that is not taken stays in place.
  a_duty_hold: assert property (@(posedge clk) disable iff (rst)
    duty_valid && !duty_ready |=> duty_valid && $stable(duty_left) && $stable(duty_right))
    else $error("duty result changed while stalled");

  // Reset leaves no result pending and the block ready for a request.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !duty_valid && frame_ready)
    else $error("block not idle after reset");

  // Work on one request blocks the next one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_ready |=> !frame_ready)
    else $error("second request taken while busy");

  // A result is only registered in the finish step, so no new result can appear right after a request.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_ready |=> !$rose(duty_valid))
    else $error("result appeared too early");

endmodule

bind differential_drive_mixer_unit ddm_checker u_ddm_checker (.*);

>>> tb/sv/differential_drive_mixer_unit_test.sv
module differential_drive_mixer_unit_test;

  typedef struct packed {
    ddm_pkg::duty_t left;
    ddm_pkg::duty_t right;
  } duty_pair_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         frame_valid = 1'b0;
  logic                         frame_ready;
  ddm_pkg::chan_t               throttle_channel = '0;
  ddm_pkg::chan_t               steer_channel = '0;
  logic                         duty_valid;
  logic                         duty_ready = 1'b0;
  ddm_pkg::duty_t               duty_left;
  ddm_pkg::duty_t               duty_right;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [ddm_pkg::ADDR_W-1:0]   paddr = '0;
  logic [ddm_pkg::DATA_W-1:0]   pwdata = '0;
  logic [ddm_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  // Mixer registers and wheel state as the block should hold them.
  logic [ddm_pkg::SENS_W-1:0]   cfg_sens;
  ddm_pkg::chan_t               cfg_min;
  ddm_pkg::chan_t               cfg_max;
  ddm_pkg::chan_t               cfg_mid;
  ddm_pkg::chan_t               cfg_center;
  ddm_pkg::chan_t               speed_left;
  ddm_pkg::chan_t               speed_right;
  ddm_pkg::chan_t               last_throttle;
  ddm_pkg::chan_t               last_left_mag;
  ddm_pkg::chan_t               last_right_mag;

  duty_pair_t          pending_duties[$];
  int                  failures = 0;
  bit                  calm = 1'b0;
  int                  stall_left = 0;

  differential_drive_mixer_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .frame_valid      (frame_valid),
    .frame_ready      (frame_ready),
    .throttle_channel (throttle_channel),
    .steer_channel    (steer_channel),
    .duty_valid       (duty_valid),
    .duty_ready       (duty_ready),
    .duty_left        (duty_left),
    .duty_right       (duty_right),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #1 clk = ~clk;

  initial begin
    #800000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic ddm_pkg::duty_t scale_speed(longint v, longint lo, longint hi);
    longint q;
    if (hi == lo) return '0;
    q = (v - lo) * 255 / (hi - lo);
    return q[ddm_pkg::DUTY_W-1:0];
  endfunction

  function automatic void reset_mixer_model();
    cfg_sens = 4'd1;
    cfg_min = 11'd172;
    cfg_max = 11'd1811;
    cfg_mid = 11'd992;
    cfg_center = 11'd991;
    speed_left = '0;
    speed_right = '0;
    last_throttle = '0;
    last_left_mag = '0;
    last_right_mag = '0;
  endfunction

  // Throttle first, then steering, then the clamped update; sums are exact.
  function automatic void mix_frame(ddm_pkg::chan_t thr_in, ddm_pkg::chan_t steer_in);
    longint thr, st, lo, hi, mid, ctr, gain, l, r, p, mag, dm, k, kabs, pl, pr;
    duty_pair_t duties;
    thr = longint'(thr_in);
    st = longint'(steer_in);
    lo = longint'(cfg_min);
    hi = longint'(cfg_max);
    mid = longint'(cfg_mid);
    ctr = longint'(cfg_center);
    gain = longint'(cfg_sens);
    l = longint'(speed_left);
    r = longint'(speed_right);
    p = longint'(last_throttle);
    pl = longint'(last_left_mag);
    pr = longint'(last_right_mag);
    if (thr != p) begin
      l += thr - p;
      r += thr - p;
      p = thr;
    end
    st = clamp_to(st, lo, hi);
    if (st < mid) begin
      mag = st - ctr;
      if (mag < 0) mag = -mag;
      dm = mag - pl;
      if (dm != 0) begin
        k = dm * gain;
        kabs = (k < 0) ? -k : k;
        if (l > p) l -= kabs;
        else if (l < p) l += kabs;
        r += k;
        last_left_mag = mag[ddm_pkg::CH_W-1:0];
      end
    end else if (st > mid) begin
      mag = st - ctr;
      dm = mag - pr;
      if (dm != 0) begin
        k = dm * gain;
        kabs = (k < 0) ? -k : k;
        l += k;
        if (r < p) r += kabs;
        else if (r > p) r -= kabs;
        // A negative magnitude is kept as its low 11 bits.
        last_right_mag = mag[ddm_pkg::CH_W-1:0];
      end
    end
    l = clamp_to(l, lo, hi);
    r = clamp_to(r, lo, hi);
    speed_left = l[ddm_pkg::CH_W-1:0];
    speed_right = r[ddm_pkg::CH_W-1:0];
    last_throttle = p[ddm_pkg::CH_W-1:0];
    duties.left = scale_speed(l, lo, hi);
    duties.right = scale_speed(r, lo, hi);
    pending_duties.push_back(duties);
  endfunction

  always @(posedge clk) begin : duty_sink
    duty_pair_t want;
    if (!rst && duty_valid && duty_ready) begin
      if (pending_duties.size() == 0) begin
        $error("duty result arrived with no request outstanding");
        failures++;
      end else begin
        want = pending_duties.pop_front();
        if (duty_left !== want.left) begin
          $error("duty_left expected %0d actual %0d", want.left, duty_left);
          failures++;
        end
        if (duty_right !== want.right) begin
          $error("duty_right expected %0d actual %0d", want.right, duty_right);
          failures++;
        end
      end
    end
    if (!calm && stall_left == 0 && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 6);
    if (stall_left > 0) begin
      duty_ready <= 1'b0;
      stall_left--;
    end else begin
      duty_ready <= 1'b1;
    end
  end

  task automatic send_frame(ddm_pkg::chan_t thr, ddm_pkg::chan_t st);
    if (!calm && $urandom_range(0, 3) == 0) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    frame_valid <= 1'b1;
    throttle_channel <= thr;
    steer_channel <= st;
    do @(posedge clk); while (!frame_ready);
    mix_frame(thr, st);
  endtask

  task automatic wait_drained();
    frame_valid <= 1'b0;
    do @(posedge clk); while (pending_duties.size() != 0);
  endtask

  task automatic write_reg(ddm_pkg::reg_idx_t idx, int unsigned value);
    case (idx)
      ddm_pkg::REG_SENSITIVITY:  cfg_sens = value[ddm_pkg::SENS_W-1:0];
      ddm_pkg::REG_CHANNEL_MIN:  cfg_min = value[ddm_pkg::CH_W-1:0];
      ddm_pkg::REG_CHANNEL_MAX:  cfg_max = value[ddm_pkg::CH_W-1:0];
      ddm_pkg::REG_CHANNEL_MID:  cfg_mid = value[ddm_pkg::CH_W-1:0];
      ddm_pkg::REG_STEER_CENTER: cfg_center = value[ddm_pkg::CH_W-1:0];
      default: ;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(int unsigned sens, int unsigned lo, int unsigned hi,
                                int unsigned mid, int unsigned ctr);
    wait_drained();
    write_reg(ddm_pkg::REG_SENSITIVITY, sens);
    write_reg(ddm_pkg::REG_CHANNEL_MIN, lo);
    write_reg(ddm_pkg::REG_CHANNEL_MAX, hi);
    write_reg(ddm_pkg::REG_CHANNEL_MID, mid);
    write_reg(ddm_pkg::REG_STEER_CENTER, ctr);
  endtask

  function automatic ddm_pkg::chan_t pick_channel(ddm_pkg::chan_t last);
    int unsigned lo, hi;
    lo = 32'(cfg_min);
    hi = 32'(cfg_max);
    case ($urandom_range(0, 9))
      0: return ddm_pkg::chan_t'($urandom_range(0, 2047));
      1: return last;
      2: return cfg_mid;
      default: return (lo < hi) ? ddm_pkg::chan_t'($urandom_range(lo, hi)) :
                                  ddm_pkg::chan_t'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic run_frames(int count);
    ddm_pkg::chan_t thr, st;
    thr = last_throttle;
    st = cfg_mid;
    repeat (count) begin
      thr = pick_channel(thr);
      st = pick_channel(st);
      send_frame(thr, st);
    end
  endtask

  task automatic pick_settings();
    int unsigned lo, hi, mid;
    if ($urandom_range(0, 5) == 0) begin
      // Anything goes, so inverted and empty ranges turn up as well.
      apply_settings($urandom_range(0, 15), $urandom_range(0, 2047), $urandom_range(0, 2047),
                     $urandom_range(0, 2047), $urandom_range(0, 2047));
    end else begin
      lo = $urandom_range(0, 700);
      hi = $urandom_range(1300, 2047);
      mid = $urandom_range(lo, hi);
      apply_settings($urandom_range(0, 15), lo, hi, mid,
                     $urandom_range(mid > 60 ? mid - 60 : 0, mid + 60));
    end
  endtask

  // Default registers: channel extremes, the steering centre and threshold, repeats.
  task automatic test_default_frames();
    send_frame(11'd0, 11'd0);
    send_frame(11'd2047, 11'd2047);
    send_frame(11'd2047, 11'd2047);
    send_frame(11'd500, 11'd992);
    // Wheels sit below the throttle, so both wheels move.
    send_frame(11'd500, 11'd500);
    send_frame(11'd500, 11'd991);
    send_frame(11'd1200, 11'd1500);
    send_frame(11'd1200, 11'd1500);
    send_frame(11'd300, 11'd172);
    send_frame(11'd1811, 11'd1811);
  endtask

  task automatic test_register_extremes();
    apply_settings(0, 172, 1811, 992, 991);
    send_frame(11'd900, 11'd300);
    send_frame(11'd900, 11'd1700);
    apply_settings(15, 0, 2047, 1024, 1024);
    send_frame(11'd2047, 11'd0);
    send_frame(11'd0, 11'd2047);
    // Inverted range: values pin to one end or the other.
    apply_settings(3, 1800, 200, 1000, 1000);
    send_frame(11'd100, 11'd50);
    send_frame(11'd1900, 11'd2000);
    // Empty range gives zero duties.
    apply_settings(7, 1000, 1000, 1000, 1000);
    send_frame(11'd1500, 11'd400);
    apply_settings(5, 100, 1900, 0, 2047);
    send_frame(11'd1000, 11'd1200);
    apply_settings(5, 100, 1900, 2047, 0);
    send_frame(11'd1000, 11'd1200);
    send_frame(11'd1000, 11'd600);
  endtask

  task automatic test_random_frames();
    for (int phase = 0; phase < 10; phase++) begin
      pick_settings();
      run_frames(25);
      if (phase == 3) wait_drained();
      run_frames(25);
    end
  endtask

  task automatic test_full_rate();
    calm = 1'b1;
    pick_settings();
    run_frames(50);
  endtask

  initial begin
    reset_mixer_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_frames();
    test_register_extremes();
    test_random_frames();
    test_full_rate();
    wait_drained();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
